[rtl/core/sitoa_pkg.sv]
package sitoa_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGITS  = 10;
  localparam int STEPS   = VALUE_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int POS_W   = $clog2(DIGITS);
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic find;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

[rtl/core/sitoa_ctrl.sv]
module sitoa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sitoa_pkg::sts_t  sts,
  output sitoa_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE = 4'b0001,
    CONV = 4'b0010,
    FIND = 4'b0100,
    EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CONV;
        end
      end
      CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_done) state_next = FIND;
      end
      FIND: begin
        cmd.find   = 1'b1;
        state_next = EMIT;
      end
      EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  assign in_ready = (state == IDLE);

endmodule

[rtl/core/sitoa_dp.sv]
module sitoa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [sitoa_pkg::VALUE_W-1:0]      value,
  input  sitoa_pkg::cmd_t                    cmd,
  output sitoa_pkg::sts_t                    sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sitoa_pkg::CHAR_W-1:0]       out_char,
  output logic                               out_last
);

  logic [sitoa_pkg::VALUE_W-1:0] mag;
  sitoa_pkg::bcd_t               bcd;
  sitoa_pkg::bcd_t               bcd_adj;
  logic [4*sitoa_pkg::DIGITS:0]  bcd_shift;
  logic [sitoa_pkg::STEP_W-1:0]  step;
  logic                          neg_pending;
  logic [sitoa_pkg::POS_W-1:0]   pos;
  logic [sitoa_pkg::POS_W-1:0]   top_pos;
  logic [3:0]                    digit;

  // add-3 correction before each shift
  always_comb begin
    for (int i = 0; i < sitoa_pkg::DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  assign bcd_shift = {bcd_adj, mag[sitoa_pkg::VALUE_W-1]};

  // highest nonzero digit, zero gives position 0
  always_comb begin
    top_pos = '0;
    for (int i = 0; i < sitoa_pkg::DIGITS; i++) begin
      if (bcd[i] != 4'd0) top_pos = sitoa_pkg::POS_W'(i);
    end
  end

  assign digit = bcd[pos];

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      neg_pending <= 1'b0;
      pos         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        step        <= '0;
        neg_pending <= value[sitoa_pkg::VALUE_W-1];
      end else if (cmd.shift) begin
        step <= step + 1'b1;
      end
      if (cmd.find) pos <= top_pos;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (neg_pending) neg_pending <= 1'b0;
        else             pos <= pos - 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= value[sitoa_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      bcd <= '0;
    end else if (cmd.shift) begin
      mag <= {mag[sitoa_pkg::VALUE_W-2:0], 1'b0};
      bcd <= bcd_shift[4*sitoa_pkg::DIGITS-1:0];
    end
    if (cmd.emit) begin
      if (neg_pending) begin
        out_char <= sitoa_pkg::ASCII_MINUS;
        out_last <= 1'b0;
      end else begin
        out_char <= sitoa_pkg::ASCII_ZERO + {4'd0, digit};
        out_last <= (pos == '0);
      end
    end
  end

  assign sts.conv_done = (step == sitoa_pkg::STEP_W'(sitoa_pkg::STEPS - 1));
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.emit_last = !neg_pending && (pos == '0);

endmodule

[rtl/core/signed_int_to_decimal_ascii_core.sv]
// Signed 32-bit integer to decimal ASCII text.
// Input channel s_*: one item carries a two's-complement value in s_tdata.
// Output channel m_*: one item per character, most significant first;
// a leading '-' for negative values, no leading zeros, tlast on the final
// character. Zero gives "0"; -2147483648 gives "-2147483648".
// Steps: a load, 32 shift-add-3 steps, locating the
// leading digit, then one character per cycle (up to 11) while m_tready
// is high. The 32-step binary-to-BCD loop and the one-character output
// register set how long a number takes.
// s_tready is high only while no number is in progress; the next value
// may be accepted while the final character still waits in the output
// register. When m_tready is low the output register holds its item and
// conversion of the current number pauses before the next character.
// Reset (rst, synchronous) returns the block to idle and drops m_tvalid.
module signed_int_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] character
  output logic        m_tlast
);

  sitoa_pkg::cmd_t cmd;
  sitoa_pkg::sts_t sts;

  sitoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sitoa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a value while busy");

  a_pending_is_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && m_tvalid |-> m_tlast)
    else $error("new value accepted before number text finished");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == sitoa_pkg::ASCII_MINUS) |-> !m_tlast)
    else $error("minus sign marked last");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == sitoa_pkg::ASCII_MINUS) ||
                 ((m_tdata >= sitoa_pkg::ASCII_ZERO) && (m_tdata <= 8'd57)))
    else $error("character out of range");

endmodule
